@@ rtl/core/ctpg_pkg.sv @@
package ctpg_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int NUM_PINS    = 32;

  localparam int ENT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int PIN_W = $clog2(NUM_PINS);

  // request codes
  localparam logic [1:0] REQ_PIN   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_ENTRY = 2'd2;

  // config register indexes
  localparam logic [2:0] CFG_ACT_DRV   = 3'd0;
  localparam logic [2:0] CFG_INACT_DRV = 3'd1;
  localparam logic [2:0] CFG_COMB_OR   = 3'd2;
  localparam logic [2:0] CFG_ON_TICKS  = 3'd3;
  localparam logic [2:0] CFG_OFF_TICKS = 3'd4;
  localparam logic [2:0] CFG_PWM_PER   = 3'd5;
  localparam logic [2:0] CFG_PWM_DUTY  = 3'd6;

  // condition modes
  localparam logic [3:0] MODE_CHANGE  = 4'd0;
  localparam logic [3:0] MODE_INC     = 4'd1;
  localparam logic [3:0] MODE_DEC     = 4'd2;
  localparam logic [3:0] MODE_EQ_C    = 4'd3;
  localparam logic [3:0] MODE_LT_C    = 4'd4;
  localparam logic [3:0] MODE_GT_C    = 4'd5;
  localparam logic [3:0] MODE_NE_C    = 4'd6;
  localparam logic [3:0] MODE_EQ_P    = 4'd7;
  localparam logic [3:0] MODE_GT_P    = 4'd8;
  localparam logic [3:0] MODE_LT_P    = 4'd9;
  localparam logic [3:0] MODE_NE_P    = 4'd10;
  localparam logic [3:0] MODE_XING_UP = 4'd11;
  localparam logic [3:0] MODE_XING_DN = 4'd12;
  localparam logic [3:0] MODE_XING    = 4'd13;

  // pulse phases
  localparam logic [1:0] PH_WAIT     = 2'd0;
  localparam logic [1:0] PH_ACTIVE   = 2'd1;
  localparam logic [1:0] PH_INACTIVE = 2'd2;

  localparam logic [15:0] CNT_STUCK = 16'hFFFF;
  localparam logic [15:0] DUTY_RST  = 16'h8000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  pin_index;
    logic [15:0] pin_value;
    logic [2:0]  entry_index;
    logic        entry_enable;
    logic [3:0]  entry_mode;
    logic [4:0]  entry_pin;
    logic [15:0] entry_operand_a;
    logic [15:0] entry_operand_b;
  } in_t;

  typedef struct packed {
    logic        drive_update;
    logic [7:0]  drive_level;
    logic        pwm_used;
    logic [15:0] pwm_level;
    logic [1:0]  pulse_phase;
    logic        condition_true;
  } out_t;

  // one condition entry as held in the entry memory
  typedef struct packed {
    logic        used;
    logic [3:0]  kind;
    logic [4:0]  watch;
    logic [15:0] ref_val;
    logic [15:0] last;
  } ent_t;

  function automatic logic pin_ok(logic [15:0] p);
    return {16'd0, p} < 32'(NUM_PINS);
  endfunction

  function automatic logic [PIN_W-1:0] pin_addr(logic [15:0] p);
    return p[PIN_W-1:0];
  endfunction

  function automatic logic ent_ok(logic [2:0] e);
    return {29'd0, e} < 32'(NUM_ENTRIES);
  endfunction

  function automatic logic [ENT_W-1:0] ent_addr(logic [2:0] e);
    logic [15:0] w;
    w = 16'(e);
    return w[ENT_W-1:0];
  endfunction

  // modes that take the watched pin as their last value when written
  function automatic logic grabs_last(logic [3:0] m);
    logic r;
    case (m) inside
      MODE_CHANGE, MODE_INC, MODE_DEC, MODE_XING_UP, MODE_XING_DN, MODE_XING: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/ctpg_ram.sv @@
module ctpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/condition_triggered_pulse_generator.sv @@
// Condition-triggered pulse generator. Pin values and condition entries sit in two
// small RAMs; per-entry valid bits make both read as zero after reset, so no clearing
// pass is needed. A pin update is written as it is accepted; an entry write passes S_EW_RD
// (one pin table read) and S_EW_WR. A tick outside the waiting phase goes to S_DONE; a
// tick in the waiting phase walks all entries: an unused entry is only read, an entry
// compared with a constant or its last value also reads the watched pin, and an entry
// compared with another pin then reads that pin too. The pin table has a single read
// port, which serves the watched pin and the other pin one after the other. A tick result
// goes to an output register; the next item is accepted while it waits, and a second
// tick result is held back until the first one is transferred.
module condition_triggered_pulse_generator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ctpg_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctpg_pkg::out_t  out_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int EW = $bits(ctpg_pkg::ent_t);
  localparam logic [ctpg_pkg::ENT_W-1:0] LAST_ENT = ctpg_pkg::ENT_W'(ctpg_pkg::NUM_ENTRIES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EW_RD  = 3'd1;  // entry write: read watched pin
  localparam logic [2:0] S_EW_WR  = 3'd2;  // entry write: store entry
  localparam logic [2:0] S_EV_ENT = 3'd3;  // entry word available
  localparam logic [2:0] S_EV_PIN = 3'd4;  // watched pin available
  localparam logic [2:0] S_EV_REF = 3'd5;  // other pin available
  localparam logic [2:0] S_DONE   = 3'd6;  // finish tick, load output

  // configuration registers
  logic [7:0]  act_drv_q, inact_drv_q;
  logic        comb_or_q;
  logic [15:0] on_ticks_q, off_ticks_q, pwm_per_q, pwm_duty_q;

  // control state
  logic [2:0]                  state_q, state_d;
  logic [ctpg_pkg::ENT_W-1:0]  cnt_q, cnt_d;
  logic                        any_q, any_d, all_q, all_d;
  logic                        cond_q, cond_d;
  logic [1:0]                  phase_q, phase_d;
  logic [15:0]                 tick_q, tick_d;
  logic                        out_valid_q, out_valid_d;
  logic [ctpg_pkg::NUM_PINS-1:0]    pin_vld_q;
  logic [ctpg_pkg::NUM_ENTRIES-1:0] ent_vld_q;
  logic                        pin_rok_q, ent_rok_q;

  // payload
  ctpg_pkg::in_t  req_q, req_d;
  logic [15:0]    v_q, v_d;
  ctpg_pkg::out_t out_q, out_d;

  // memory ports
  logic                        pin_we, pin_re;
  logic [15:0]                 pin_wsrc, pin_rsrc, pin_wdata, pin_rdata;
  logic                        ent_we, ent_re;
  logic [ctpg_pkg::ENT_W-1:0]  ent_waddr, ent_raddr;
  ctpg_pkg::ent_t              ent_wdata;
  logic [EW-1:0]               ent_rdata;

  ctpg_pkg::ent_t ent_cur;
  logic [15:0]    pin_rd, v_now;
  logic           pin_mode, contrib, cmp_true, hit, miss, adv, acc, any_n, all_n;
  logic           accept, load;

  ctpg_ram #(.WIDTH(16), .DEPTH(ctpg_pkg::NUM_PINS)) u_pin_ram (
    .clk_i   (clk_i),
    .we_i    (pin_we),
    .waddr_i (ctpg_pkg::pin_addr(pin_wsrc)),
    .wdata_i (pin_wdata),
    .re_i    (pin_re),
    .raddr_i (ctpg_pkg::pin_addr(pin_rsrc)),
    .rdata_o (pin_rdata)
  );

  ctpg_ram #(.WIDTH(EW), .DEPTH(ctpg_pkg::NUM_ENTRIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // never-written entries and pins read as zero
  assign pin_rd  = pin_rok_q ? pin_rdata : 16'd0;
  assign ent_cur = ent_rok_q ? ctpg_pkg::ent_t'(ent_rdata) : '0;
  assign v_now   = (state_q == S_EV_REF) ? v_q : pin_rd;

  // compare one entry; in S_EV_REF the other pin is on the read port
  always_comb begin
    contrib  = 1'b1;
    cmp_true = 1'b0;
    pin_mode = 1'b0;
    case (ent_cur.kind)
      ctpg_pkg::MODE_CHANGE: cmp_true = (v_now != ent_cur.last);
      ctpg_pkg::MODE_INC:    cmp_true = (v_now > ent_cur.last);
      ctpg_pkg::MODE_DEC:    cmp_true = (v_now < ent_cur.last);
      ctpg_pkg::MODE_EQ_C:   cmp_true = (v_now == ent_cur.ref_val);
      ctpg_pkg::MODE_LT_C:   cmp_true = (v_now < ent_cur.ref_val);
      ctpg_pkg::MODE_GT_C:   cmp_true = (v_now > ent_cur.ref_val);
      ctpg_pkg::MODE_NE_C:   cmp_true = (v_now != ent_cur.ref_val);
      ctpg_pkg::MODE_EQ_P: begin
        pin_mode = 1'b1;
        cmp_true = (v_now == pin_rd);
      end
      ctpg_pkg::MODE_GT_P: begin
        pin_mode = 1'b1;
        cmp_true = (v_now > pin_rd);
      end
      ctpg_pkg::MODE_LT_P: begin
        pin_mode = 1'b1;
        cmp_true = (v_now < pin_rd);
      end
      ctpg_pkg::MODE_NE_P: begin
        pin_mode = 1'b1;
        cmp_true = (v_now != pin_rd);
      end
      default: contrib = 1'b0;  // crossing modes and unused codes do nothing
    endcase
  end

  assign hit  = contrib && cmp_true;
  assign miss = contrib && !cmp_true;
  assign acc  = ((state_q == S_EV_PIN) && !pin_mode) || (state_q == S_EV_REF);
  assign adv  = ((state_q == S_EV_ENT) && !ent_cur.used) || acc;
  assign any_n = any_q | (acc & hit);
  assign all_n = all_q & ~(acc & miss);
  assign load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    any_d     = any_q;
    all_d     = all_q;
    cond_d    = cond_q;
    req_d     = req_q;
    v_d       = v_q;
    pin_we    = 1'b0;
    pin_wsrc  = 16'(in_i.pin_index);
    pin_wdata = in_i.pin_value;
    pin_re    = 1'b0;
    pin_rsrc  = 16'(ent_cur.watch);
    ent_we    = 1'b0;
    ent_waddr = cnt_q;
    ent_wdata = ent_cur;
    ent_wdata.last = v_now;
    ent_re    = 1'b0;
    ent_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = in_i;
          unique case (in_i.req_type)
            ctpg_pkg::REQ_PIN: begin
              pin_we = ctpg_pkg::pin_ok(pin_wsrc);
            end
            ctpg_pkg::REQ_ENTRY: state_d = S_EW_RD;
            ctpg_pkg::REQ_TICK: begin
              if (phase_q == ctpg_pkg::PH_WAIT) begin
                ent_re  = 1'b1;
                cnt_d   = '0;
                any_d   = 1'b0;
                all_d   = 1'b1;
                state_d = S_EV_ENT;
              end else begin
                cond_d  = 1'b0;
                state_d = S_DONE;
              end
            end
            default: ;  // unknown request: dropped
          endcase
        end
      end
      S_EW_RD: begin
        pin_re   = 1'b1;
        pin_rsrc = 16'(req_q.entry_pin);
        state_d  = S_EW_WR;
      end
      S_EW_WR: begin
        ent_we          = ctpg_pkg::ent_ok(req_q.entry_index);
        ent_waddr       = ctpg_pkg::ent_addr(req_q.entry_index);
        ent_wdata.used  = req_q.entry_enable;
        ent_wdata.kind  = req_q.entry_mode;
        ent_wdata.watch = req_q.entry_pin;
        ent_wdata.ref_val = req_q.entry_operand_a;
        ent_wdata.last  = ctpg_pkg::grabs_last(req_q.entry_mode) ?
                          pin_rd : req_q.entry_operand_b;
        state_d         = S_IDLE;
      end
      S_EV_ENT: begin
        if (ent_cur.used) begin
          pin_re  = 1'b1;
          state_d = S_EV_PIN;
        end
      end
      S_EV_PIN: begin
        if (pin_mode) begin
          v_d      = pin_rd;
          pin_re   = 1'b1;
          pin_rsrc = ent_cur.ref_val;
          state_d  = S_EV_REF;
        end else begin
          // change modes keep the current value as the new last value
          ent_we = (ent_cur.kind == ctpg_pkg::MODE_CHANGE) ||
                   (ent_cur.kind == ctpg_pkg::MODE_INC) ||
                   (ent_cur.kind == ctpg_pkg::MODE_DEC);
        end
      end
      S_EV_REF: ;
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // step to the next entry, or finish the walk
    if (adv) begin
      any_d = any_n;
      all_d = all_n;
      if (cnt_q == LAST_ENT) begin
        cond_d  = comb_or_q ? any_n : all_n;
        state_d = S_DONE;
      end else begin
        cnt_d     = cnt_q + 1'b1;
        ent_re    = 1'b1;
        ent_raddr = cnt_q + 1'b1;
        state_d   = S_EV_ENT;
      end
    end
  end

  // phase update and result on the closing cycle of a tick
  always_comb begin
    logic drv_en, drv_act;
    drv_en  = 1'b0;
    drv_act = 1'b0;
    phase_d = phase_q;
    tick_d  = tick_q;
    unique case (phase_q)
      ctpg_pkg::PH_WAIT: begin
        drv_en = 1'b1;
        if (cond_q) begin
          drv_act = 1'b1;
          tick_d  = on_ticks_q;
          phase_d = ctpg_pkg::PH_ACTIVE;
        end
      end
      ctpg_pkg::PH_ACTIVE: begin
        // an all-ones count ends the on period like zero
        if (tick_q != 16'd0 && tick_q != ctpg_pkg::CNT_STUCK) begin
          tick_d = tick_q - 16'd1;
        end else if (off_ticks_q != 16'd0) begin
          tick_d  = off_ticks_q;
          phase_d = ctpg_pkg::PH_INACTIVE;
        end else begin
          phase_d = ctpg_pkg::PH_WAIT;
        end
      end
      ctpg_pkg::PH_INACTIVE: begin
        if (tick_q != 16'd0) begin
          tick_d = tick_q - 16'd1;
          drv_en = 1'b1;
        end else begin
          tick_d  = on_ticks_q;
          phase_d = ctpg_pkg::PH_WAIT;
        end
      end
      default: phase_d = ctpg_pkg::PH_WAIT;
    endcase

    out_d                = '0;
    out_d.drive_update   = drv_en;
    out_d.pulse_phase    = phase_d;
    out_d.condition_true = cond_q;
    if (drv_en) begin
      if (pwm_per_q != 16'd0) begin
        out_d.pwm_used  = 1'b1;
        out_d.pwm_level = drv_act ? pwm_duty_q : 16'd0;
      end else begin
        out_d.drive_level = drv_act ? act_drv_q : inact_drv_q;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      any_q       <= 1'b0;
      all_q       <= 1'b1;
      cond_q      <= 1'b0;
      phase_q     <= ctpg_pkg::PH_WAIT;
      tick_q      <= 16'd0;
      out_valid_q <= 1'b0;
      pin_vld_q   <= '0;
      ent_vld_q   <= '0;
      pin_rok_q   <= 1'b0;
      ent_rok_q   <= 1'b0;
      act_drv_q   <= 8'd0;
      inact_drv_q <= 8'd0;
      comb_or_q   <= 1'b0;
      on_ticks_q  <= 16'd0;
      off_ticks_q <= 16'd0;
      pwm_per_q   <= 16'd0;
      pwm_duty_q  <= ctpg_pkg::DUTY_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      any_q       <= any_d;
      all_q       <= all_d;
      cond_q      <= cond_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
      end
      if (pin_we) begin
        pin_vld_q[ctpg_pkg::pin_addr(pin_wsrc)] <= 1'b1;
      end
      if (ent_we) begin
        ent_vld_q[ent_waddr] <= 1'b1;
      end
      if (pin_re) begin
        pin_rok_q <= ctpg_pkg::pin_ok(pin_rsrc) &&
                     pin_vld_q[ctpg_pkg::pin_addr(pin_rsrc)];
      end
      if (ent_re) begin
        ent_rok_q <= ent_vld_q[ent_raddr];
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ctpg_pkg::CFG_ACT_DRV:   act_drv_q   <= cfg_data_i[7:0];
          ctpg_pkg::CFG_INACT_DRV: inact_drv_q <= cfg_data_i[7:0];
          ctpg_pkg::CFG_COMB_OR:   comb_or_q   <= cfg_data_i[0];
          ctpg_pkg::CFG_ON_TICKS:  on_ticks_q  <= cfg_data_i;
          ctpg_pkg::CFG_OFF_TICKS: off_ticks_q <= cfg_data_i;
          ctpg_pkg::CFG_PWM_PER:   pwm_per_q   <= cfg_data_i;
          ctpg_pkg::CFG_PWM_DUTY:  pwm_duty_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    v_q   <= v_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  // a finished tick waits while the previous result is not taken
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("tick result overwrote a pending result");

  // a tick outside the waiting phase skips the entry walk
  a_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.req_type == ctpg_pkg::REQ_TICK && phase_q != ctpg_pkg::PH_WAIT)
    |=> (state_q == S_DONE))
    else $error("entry walk started outside waiting phase");

  // the off period only follows an on period
  a_phase_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ctpg_pkg::PH_INACTIVE && $past(phase_q) != ctpg_pkg::PH_INACTIVE)
    |-> ($past(phase_q) == ctpg_pkg::PH_ACTIVE))
    else $error("inactive phase entered from waiting");

  // condition only reported on a tick that started in the waiting phase
  a_cond_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cond_q) |-> (phase_q == ctpg_pkg::PH_WAIT))
    else $error("condition flagged outside waiting phase");

endmodule
